### hw/rtl/fcs_pkg.sv
// fcs_pkg: shared constants and word types for the flash transfer chunk splitter
// used by fcs_front, fcs_desc_fifo, fcs_back and the top level; no dependencies
package fcs_pkg;

    // transfer geometry; PAGE_BYTES must be a power of two
    localparam int PAGE_BYTES  = 256;
    localparam int READ_CHUNK  = 255;
    localparam int MAX_REQUEST = 4096;
    localparam int MAX_CHUNKS  = 64;

    // field widths fixed by the word formats
    localparam int ADDR_W = 24;
    localparam int CNT_W  = 13;
    localparam int LEN_W  = 9;
    localparam int OFF_W  = 12;

    // derived widths
    localparam int PAGE_W  = $clog2(PAGE_BYTES);
    localparam int CHUNK_W = $clog2(MAX_CHUNKS);

    // descriptor queue between front and back
    localparam int DESC_DEPTH = 2;
    localparam int DPTR_W     = $clog2(DESC_DEPTH);
    localparam int DCNT_W     = $clog2(DESC_DEPTH + 1);

    localparam logic [LEN_W-1:0] PAGE_LEN    = LEN_W'(PAGE_BYTES);
    localparam logic [LEN_W-1:0] READ_LEN    = LEN_W'(READ_CHUNK);
    localparam logic [CNT_W-1:0] MAX_REQ_CNT = CNT_W'(MAX_REQUEST);

    // command codes
    typedef enum logic {
        CMD_PROGRAM = 1'b0,
        CMD_READ    = 1'b1
    } fcs_cmd_t;

    // request word on the input side
    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] start_address;
        logic [CNT_W-1:0]  byte_count;
    } fcs_req_t;

    // chunk word on the result side
    typedef struct packed {
        logic [ADDR_W-1:0] chunk_address;
        logic [LEN_W-1:0]  chunk_length;
        logic [OFF_W-1:0]  buffer_offset;
        logic              first_chunk;
        logic              last_chunk;
    } fcs_chunk_t;

    // classified request handed from front to back
    typedef struct packed {
        logic              is_read;
        logic [ADDR_W-1:0] start;
        logic [CNT_W-1:0]  count;
        logic [LEN_W-1:0]  first_len;
    } fcs_desc_t;

endpackage

### hw/rtl/fcs_front.sv
// fcs_front: accepts request words, saturates the count and works out the
// first chunk's length; depends on fcs_pkg
module fcs_front
    import fcs_pkg::*;
(
    input  fcs_req_t  req,
    input  logic      push,
    input  logic      q_full,
    output logic      q_wr,
    output fcs_desc_t q_desc
);

    logic [CNT_W-1:0]  sat_count;
    logic [LEN_W-1:0]  page_rest;
    logic              is_read;

    // clamp the count to the largest request
    assign sat_count = (req.byte_count > MAX_REQ_CNT) ? MAX_REQ_CNT : req.byte_count;

    // bytes left up to the end of the start page
    assign page_rest = PAGE_LEN - LEN_W'(req.start_address[PAGE_W-1:0]);

    assign is_read = (req.cmd == CMD_READ);

    // a zero count produces nothing, so it never reaches the queue
    assign q_wr = push && !q_full && (sat_count != '0);

    assign q_desc.is_read   = is_read;
    assign q_desc.start     = req.start_address;
    assign q_desc.count     = sat_count;
    assign q_desc.first_len = is_read ? READ_LEN : page_rest;

endmodule

### hw/rtl/fcs_desc_fifo.sv
// fcs_desc_fifo: short descriptor queue that decouples front and back
// depends on fcs_pkg
module fcs_desc_fifo
    import fcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  fcs_desc_t wr_desc,
    input  logic      rd,
    output fcs_desc_t rd_desc,
    output logic      full,
    output logic      not_empty
);

    fcs_desc_t          mem [DESC_DEPTH];
    logic [DPTR_W-1:0]  wr_ptr_reg;
    logic [DPTR_W-1:0]  rd_ptr_reg;
    logic [DCNT_W-1:0]  count_reg;
    logic               do_wr;
    logic               do_rd;

    assign full      = (count_reg == DCNT_W'(DESC_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr && !full;
    assign do_rd     = rd && not_empty;
    assign rd_desc   = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_desc;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == DPTR_W'(DESC_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == DPTR_W'(DESC_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/fcs_back.sv
// fcs_back: chunk sequencer that walks one descriptor into an output register, one
// chunk word per cycle while that register is free or popped; depends on fcs_pkg
module fcs_back
    import fcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  fcs_desc_t  q_desc,
    input  logic       q_valid,
    output logic       q_rd,
    output fcs_chunk_t chunk,
    output logic       empty,
    input  logic       pop
);

    logic               active_reg,    active_next;
    logic               out_valid_reg, out_valid_next;
    logic               is_read_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [OFF_W-1:0]   offset_reg;
    logic [CHUNK_W-1:0] n_reg;
    logic [LEN_W-1:0]   first_len_reg;
    fcs_chunk_t         out_reg,       out_next;

    logic               load;
    logic               emit;
    logic [LEN_W-1:0]   full_len;
    logic [LEN_W-1:0]   cur_len;
    logic [CNT_W-1:0]   rem_next;
    logic               last;

    assign empty = !out_valid_reg;
    assign chunk = out_reg;

    // handshake between the sequencer and the output register
    assign load = !active_reg && q_valid;
    assign emit = active_reg && (!out_valid_reg || pop);
    assign q_rd = load;

    // length of the current chunk
    always_comb
    begin
        if (n_reg == '0)
        begin
            full_len = first_len_reg;
        end
        else
        begin
            full_len = is_read_reg ? READ_LEN : PAGE_LEN;
        end
        cur_len  = (CNT_W'(full_len) > rem_reg) ? rem_reg[LEN_W-1:0] : full_len;
        rem_next = rem_reg - CNT_W'(cur_len);
        last     = (rem_next == '0) || (n_reg == CHUNK_W'(MAX_CHUNKS - 1));
    end

    // next control state and next chunk word
    always_comb
    begin
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            active_next = 1'b1;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (last)
            begin
                active_next = 1'b0;
            end
        end
        out_next.chunk_address = addr_reg;
        out_next.chunk_length  = cur_len;
        out_next.buffer_offset = offset_reg;
        out_next.first_chunk   = (n_reg == '0);
        out_next.last_chunk    = last;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // walk registers and output word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            is_read_reg   <= q_desc.is_read;
            addr_reg      <= q_desc.start;
            rem_reg       <= q_desc.count;
            first_len_reg <= q_desc.first_len;
            offset_reg    <= '0;
            n_reg         <= '0;
        end
        else if (emit)
        begin
            addr_reg   <= addr_reg + ADDR_W'(cur_len);
            rem_reg    <= rem_next;
            offset_reg <= offset_reg + OFF_W'(cur_len);
            n_reg      <= n_reg + 1'b1;
        end
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

endmodule

### hw/rtl/flash_transfer_chunk_splitter.sv
// flash_transfer_chunk_splitter: splits serial-flash transfer requests into chunks
// a request is queued, loaded into the back sequencer, then walked into chunk words
// throughput: one chunk word per cycle while the output register is free or popped;
// a new descriptor is taken from the two-entry queue only after the last chunk
// reset: asynchronous; clears queue pointers, sequencer state and output valid flag
// depends on fcs_pkg, fcs_front, fcs_desc_fifo, fcs_back
module flash_transfer_chunk_splitter
    import fcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  fcs_req_t   req,
    input  logic       push,
    output logic       full,
    output fcs_chunk_t chunk,
    output logic       empty,
    input  logic       pop
);

    logic      q_wr;
    logic      q_rd;
    logic      q_full;
    logic      q_valid;
    fcs_desc_t q_wr_desc;
    fcs_desc_t q_rd_desc;

    assign full = q_full;

    // request classification
    fcs_front u_front (
        .req    (req),
        .push   (push),
        .q_full (q_full),
        .q_wr   (q_wr),
        .q_desc (q_wr_desc)
    );

    // descriptor queue
    fcs_desc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (q_wr),
        .wr_desc   (q_wr_desc),
        .rd        (q_rd),
        .rd_desc   (q_rd_desc),
        .full      (q_full),
        .not_empty (q_valid)
    );

    // chunk sequencer
    fcs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_desc  (q_rd_desc),
        .q_valid (q_valid),
        .q_rd    (q_rd),
        .chunk   (chunk),
        .empty   (empty),
        .pop     (pop)
    );

endmodule
